/* design/fet_pkg.sv */
// Shared types and constants for the FIFO eviction tracker.
// Used by fet_ctrl, fet_dp and fifo_eviction_tracker; no dependencies.
`default_nettype none

package fet_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int BLOCK_ID_W      = 16;
  localparam int CFG_W           = 5;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_W-1:0]     CAPACITY_RESET = 5'd10;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_MODE   = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch item, arm the search
    logic append;     // write at tail, grow list
    logic rd_head;    // read oldest entry
    logic ev_wr;      // write at tail, drop oldest
    logic scan;       // issue next search read
    logic swap_pos;   // newest entry into the matching slot
    logic swap_last;  // item into the newest slot
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic append_ok;
    logic hit_mode;
    logic match;
    logic scan_end;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/fet_ctrl.sv */
// Sequencer for the FIFO eviction tracker: steps append, evict and search.
// Depends on fet_pkg; drives fet_dp through dp_cmd_t.
`default_nettype none

module fet_ctrl
  import fet_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  output logic          done,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_EV_RD,
    S_EV_WR,
    S_SCAN,
    S_SWAP
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.append_ok) begin
            state_next = S_APPEND;
          end else if (stat.hit_mode) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EV_RD;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_IDLE;
      end
      S_EV_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_EV_WR;
      end
      S_EV_WR: begin
        cmd.ev_wr  = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.swap_pos = 1'b1;
          state_next   = S_SWAP;
        end else if (stat.scan_end) begin
          // miss: head entry is already in the read register
          state_next = S_EV_WR;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SWAP: begin
        cmd.swap_last = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_APPEND) || (state == S_EV_WR) || (state == S_SWAP);
    end
  end

endmodule

`default_nettype wire

/* design/fet_dp.sv */
// Datapath for the FIFO eviction tracker: config registers, circular id
// store, search pipeline and result registers. Depends on fet_pkg.
`default_nettype none

module fet_dp
  import fet_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [BLOCK_ID_W-1:0] block_id,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic                       hit,
  output logic                       evict_valid,
  output logic [BLOCK_ID_W-1:0]      evict_id
);

  localparam int KEEP_W = (ID_BITS < BLOCK_ID_W) ? ID_BITS : BLOCK_ID_W;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CMP_W  = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;

  logic [CFG_W-1:0]  capacity;
  logic              hit_mode;
  logic [FILL_W-1:0] fill;
  logic [ADDR_W-1:0] head;
  logic [KEEP_W-1:0] id_q;

  logic [KEEP_W-1:0] mem [MAX_ENTRIES];
  logic [KEEP_W-1:0] rdata;

  logic [FILL_W-1:0] cnt;
  logic              cmp_valid;
  logic              cmp_first;
  logic [ADDR_W-1:0] cmp_addr;
  logic [KEEP_W-1:0] last_data;

  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  fill_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic [ADDR_W-1:0] tail_addr;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] head_next;
  logic              empty;
  logic              issue;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [KEEP_W-1:0] wdata;

  function automatic logic [ADDR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [ADDR_W-1:0] r;
    if (s >= SUM_W'(MAX_ENTRIES)) begin
      r = ADDR_W'(s - SUM_W'(MAX_ENTRIES));
    end else begin
      r = ADDR_W'(s);
    end
    return r;
  endfunction

  assign cap_ext  = CMP_W'(capacity);
  assign fill_ext = CMP_W'(fill);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign empty     = (fill == '0);
  assign tail_addr = wrap(SUM_W'(head) + SUM_W'(fill));
  assign last_addr = wrap(SUM_W'(head) + SUM_W'(fill) - SUM_W'(1));
  assign scan_addr = wrap(SUM_W'(head) + SUM_W'(cnt) - SUM_W'(1));
  assign head_next = wrap(SUM_W'(head) + SUM_W'(1));
  assign issue     = cmd.scan && (cnt != '0);

  assign stat.append_ok = hit_mode ? (fill_ext < eff_cap)
                                   : ((fill_ext + CMP_W'(1)) < eff_cap);
  assign stat.hit_mode  = hit_mode;
  assign stat.match     = cmp_valid && (rdata == id_q);
  assign stat.scan_end  = (cnt == '0) && !cmp_valid;

  always_comb begin
    we    = 1'b0;
    waddr = tail_addr;
    wdata = id_q;
    if (cmd.append) begin
      we = 1'b1;
    end else if (cmd.ev_wr) begin
      we = !empty;
    end else if (cmd.swap_pos) begin
      we    = 1'b1;
      waddr = cmp_addr;
      wdata = cmp_first ? rdata : last_data;
    end else if (cmd.swap_last) begin
      we    = 1'b1;
      waddr = last_addr;
    end
  end

  assign re    = cmd.rd_head || issue;
  assign raddr = cmd.rd_head ? head : scan_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q <= KEEP_W'(block_id);
    end
    if (issue) begin
      cmp_addr  <= scan_addr;
      cmp_first <= (cnt == fill);
    end
    if (cmp_valid && cmp_first) begin
      last_data <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAPACITY_RESET;
      hit_mode    <= 1'b0;
      fill        <= '0;
      head        <= '0;
      cnt         <= '0;
      cmp_valid   <= 1'b0;
      hit         <= 1'b0;
      evict_valid <= 1'b0;
      evict_id    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY: capacity <= cfg_data;
          REG_HIT_MODE: hit_mode <= cfg_data[0];
          default: ;
        endcase
      end
      cmp_valid <= issue;
      if (cmd.load) begin
        cnt <= fill;
      end else if (issue) begin
        cnt <= cnt - FILL_W'(1);
      end
      if (cmd.append) begin
        fill        <= fill + FILL_W'(1);
        hit         <= 1'b0;
        evict_valid <= 1'b0;
        evict_id    <= '0;
      end
      if (cmd.ev_wr) begin
        if (!empty) begin
          head <= head_next;
        end
        hit         <= 1'b0;
        evict_valid <= 1'b1;
        evict_id    <= BLOCK_ID_W'(empty ? id_q : rdata);
      end
      if (cmd.swap_last) begin
        hit         <= 1'b1;
        evict_valid <= 1'b0;
        evict_id    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/fifo_eviction_tracker.sv */
// FIFO eviction tracker: start/busy command port, done strobe per item.
// An append writes at the tail; an eviction reads the head, then writes at
// the tail; a hit-mode search reads one entry a cycle, newest first, from the
// id store (one read, one write port) and evicts on a miss. The next item is
// taken in the done cycle. Sync reset empties the list, capacity 10, hit_mode 0;
// the store itself is not cleared. The receiver cannot stall.
`default_nettype none

module fifo_eviction_tracker
  import fet_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [BLOCK_ID_W-1:0] block_id,
  output logic                       done,
  output logic                       hit,
  output logic                       evict_valid,
  output logic [BLOCK_ID_W-1:0]      evict_id
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fet_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  fet_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .block_id    (block_id),
    .cmd         (cmd),
    .stat        (stat),
    .hit         (hit),
    .evict_valid (evict_valid),
    .evict_id    (evict_id)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evict_valid && evict_id == '0))
    else $error("hit item reports an eviction");
`endif

endmodule

`default_nettype wire

/* tb/fifo_eviction_tracker_test.sv */
// Self-checking testbench for fifo_eviction_tracker: a directed table, then random phases.
// Every item is checked against a behavioural tracker of the list, or against the typed outcome of its directed row.
// Depends on fet_pkg and fifo_eviction_tracker.
`default_nettype none

module fifo_eviction_tracker_test
  import fet_pkg::*;
();

  localparam int LIST_DEPTH = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_FROM = 1700;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
  localparam int N_DIRECTED = 24;

  typedef struct packed {
    logic                  hit;
    logic                  evict_valid;
    logic [BLOCK_ID_W-1:0] evict_id;
  } outcome_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [BLOCK_ID_W-1:0] value;
    bit                   typed;
    outcome_t             want;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  start;
  logic                  busy;
  logic [BLOCK_ID_W-1:0] block_id;
  logic                  done;
  logic                  hit;
  logic                  evict_valid;
  logic [BLOCK_ID_W-1:0] evict_id;

  // typed expectation travelling with the item being offered
  bit       item_typed;
  outcome_t item_want;

  // tracker state
  logic [BLOCK_ID_W-1:0] id_list [LIST_DEPTH];
  int                    list_fill;
  logic [CFG_W-1:0]      cap_reg;
  logic                  mode_reg;

  outcome_t expected_outcomes [$];
  int       err_count;
  int       quiet_cycles;

  fifo_eviction_tracker u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .block_id   (block_id),
    .done       (done),
    .hit        (hit),
    .evict_valid(evict_valid),
    .evict_id   (evict_id)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // append at the tail and drop the oldest; returns the dropped id (the id itself for an empty list)
  function automatic logic [BLOCK_ID_W-1:0] shift_in(input logic [BLOCK_ID_W-1:0] id);
    logic [BLOCK_ID_W-1:0] oldest;
    if (list_fill == 0) return id;
    oldest = id_list[0];
    for (int i = 1; i < list_fill; i++) id_list[i-1] = id_list[i];
    id_list[list_fill-1] = id;
    return oldest;
  endfunction

  function automatic outcome_t track_request(input logic [BLOCK_ID_W-1:0] id);
    outcome_t              r;
    int                    cap;
    int                    pos;
    logic [BLOCK_ID_W-1:0] tmp;
    r = '0;
    cap = int'(cap_reg);
    if (cap < 1) cap = 1;
    if (cap > LIST_DEPTH) cap = LIST_DEPTH;
    if (!mode_reg) begin
      if (list_fill + 1 < cap) begin
        id_list[list_fill] = id;
        list_fill++;
      end else begin
        r.evict_valid = 1'b1;
        r.evict_id = shift_in(id);
      end
    end else if (list_fill < cap) begin
      id_list[list_fill] = id;
      list_fill++;
    end else begin
      pos = -1;
      for (int i = list_fill - 1; i >= 0; i--)
        if (pos < 0 && id_list[i] == id) pos = i;
      if (pos >= 0) begin
        tmp = id_list[list_fill-1];
        id_list[list_fill-1] = id_list[pos];
        id_list[pos] = tmp;
        r.hit = 1'b1;
      end else begin
        r.evict_valid = 1'b1;
        r.evict_id = shift_in(id);
      end
    end
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = BLOCK_ID_W'(val);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t item_row(input logic [BLOCK_ID_W-1:0] id, input bit typed,
                                    input outcome_t want);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.value = id;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // checker, tracker update and watchdog
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    outcome_t predicted;
    bit       active;
    active = 1'b0;
    if (!rst) begin
      if (done) begin
        active = 1'b1;
        got = '{hit, evict_valid, evict_id};
        if (expected_outcomes.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: hit=%0b evict_valid=%0b evict_id=%h",
                     got.hit, got.evict_valid, got.evict_id);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected hit=%0b ev=%0b id=%h, got hit=%0b ev=%0b id=%h",
                       want.hit, want.evict_valid, want.evict_id,
                       got.hit, got.evict_valid, got.evict_id);
          end
        end
      end
      if (cfg_we) begin
        active = 1'b1;
        case (cfg_index)
          REG_CAPACITY: cap_reg = cfg_data;
          REG_HIT_MODE: mode_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        active = 1'b1;
        predicted = track_request(block_id);
        if (item_typed) predicted = item_want;
        expected_outcomes.insert(expected_outcomes.size(), predicted);
      end
    end
    if (active || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [BLOCK_ID_W-1:0] id, input bit typed,
                           input outcome_t want);
    start <= 1'b1;
    block_id <= id;
    item_typed <= typed;
    item_want <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // registers change only with the list idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    start <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0 || busy);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    row_t                  directed [N_DIRECTED];
    logic [BLOCK_ID_W-1:0] pool [24];
    int                    pool_n;
    int                    sent;
    int                    n;
    int                    pick;
    bit                    calm;
    logic [CFG_W-1:0]      cap_val;
    logic [BLOCK_ID_W-1:0] id;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    block_id = '0;
    item_typed = 1'b0;
    item_want = '0;
    err_count = 0;
    quiet_cycles = 0;
    list_fill = 0;
    cap_reg = CAPACITY_RESET;
    mode_reg = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) id_list[i] = '0;

    directed = '{
      cfg_row(REG_CAPACITY, 1),
      item_row(16'hA5A5, 1'b1, '{1'b0, 1'b1, 16'hA5A5}),  // evicted from an empty list
      item_row(16'hFFFF, 1'b1, '{1'b0, 1'b1, 16'hFFFF}),
      cfg_row(REG_CAPACITY, 0),                          // zero acts as one
      item_row(16'h0000, 1'b1, '{1'b0, 1'b1, 16'h0000}),
      cfg_row(REG_CAPACITY, 3),
      item_row(16'h0001, 1'b1, '{1'b0, 1'b0, 16'h0000}),
      item_row(16'h0002, 1'b1, '{1'b0, 1'b0, 16'h0000}),
      item_row(16'h0003, 1'b1, '{1'b0, 1'b1, 16'h0001}),
      cfg_row(REG_HIT_MODE, 1),
      item_row(16'h0002, 1'b0, '0),                      // fills to capacity
      item_row(16'h0002, 1'b0, '0),                      // newest slot, two matches
      item_row(16'h0003, 1'b0, '0),
      item_row(16'h0002, 1'b0, '0),
      item_row(16'h0009, 1'b0, '0),                      // miss evicts
      item_row(16'h0003, 1'b0, '0),                      // match at oldest slot
      cfg_row(REG_CAPACITY, 1),                          // below the fill
      item_row(16'hFFFF, 1'b0, '0),
      item_row(16'h0002, 1'b0, '0),
      cfg_row(REG_HIT_MODE, 0),
      cfg_row(REG_CAPACITY, 2),
      item_row(16'h8000, 1'b0, '0),
      cfg_row(REG_CAPACITY, 31),                         // saturates
      item_row(16'h7FFF, 1'b0, '0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg)
        write_reg(directed[i].idx, CFG_W'(directed[i].value));
      else
        send_item(directed[i].value, directed[i].typed, directed[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: cap_val = 5'd0;
        1: cap_val = 5'd1;
        2: cap_val = 5'd16;
        3: cap_val = CFG_W'($urandom_range(17, 31));
        default: cap_val = CFG_W'($urandom_range(1, 16));
      endcase
      write_reg(REG_CAPACITY, cap_val);
      if ($urandom_range(0, 2) != 0) write_reg(REG_HIT_MODE, CFG_W'($urandom));
      pool_n = $urandom_range(1, 24);
      for (int k = 0; k < 24; k++) pool[k] = BLOCK_ID_W'($urandom);
      n = $urandom_range(30, 120);
      calm = (sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) id = BLOCK_ID_W'($urandom);
        else if (pick == 1) id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else id = pool[$urandom_range(0, pool_n - 1)];
        send_item(id, 1'b0, '0);
        sent++;
        if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 16));
      end
    end

    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
